### sv/generational_ticket_slot_table_defines.svh
// Assertion macros for the generational ticket slot table.
`ifndef GENERATIONAL_TICKET_SLOT_TABLE_DEFINES_SVH
`define GENERATIONAL_TICKET_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GTST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtst check failed");

// Next-cycle implication, disabled while reset is high.
`define GTST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtst check failed");

`endif

### sv/gtst_pkg.sv
// Shared constants and types for the generational ticket slot table.
`timescale 1ns / 1ps

package gtst_pkg;

   localparam int DEF_SLOTS   = 256;
   localparam int LOOP_SHIFT  = 56;
   localparam int SLOT_SHIFT  = 32;
   localparam int GEN_W       = 30;
   localparam int HANDLE_W    = 32;
   localparam int LOOP_W      = 8;
   localparam int SLOT_FLD_W  = 16;
   localparam int TICKET_W    = 64;

   typedef enum logic [2:0] {
      REQ_ARM     = 3'd0,
      REQ_CLAIM   = 3'd1,
      REQ_RELEASE = 3'd2,
      REQ_FORGET  = 3'd3,
      REQ_SCAN    = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_ARMED    = 2'd1,
      PH_RESUMING = 2'd2
   } phase_type;

endpackage

### sv/generational_ticket_slot_table.sv
// Generational ticket slot table: slot memory with read-modify-write control.
`timescale 1ns / 1ps
`include "generational_ticket_slot_table_defines.svh"

// Channel   Ports                                   Transfer
// request   start, busy, req_*                      start && !busy at clock edge
// result    rsp_valid, rsp_*                        rsp_valid high for one cycle
// config    csr_we, csr_wdata                       csr_we at clock edge
//
// Arm, claim, release and forget each do one memory read, then modify and write back.
// A scan reads the slots it passes over in turn, one slot per cycle on the read port.
// After reset a clearing pass writes every slot, with busy high.
// The result register holds for one cycle while the next request is taken; no stalls.
module generational_ticket_slot_table #(
   parameter int SLOTS = gtst_pkg::DEF_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_type,
   input  logic [gtst_pkg::TICKET_W-1:0]     req_ticket,
   input  logic [gtst_pkg::SLOT_FLD_W-1:0]   req_slot_index,
   input  logic [gtst_pkg::GEN_W-1:0]        req_generation,
   input  logic [gtst_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [gtst_pkg::HANDLE_W-1:0]     req_work_handle,
   output logic                              rsp_valid,
   output logic                              rsp_success,
   output logic [gtst_pkg::TICKET_W-1:0]     rsp_new_ticket,
   output logic [gtst_pkg::SLOT_FLD_W-1:0]   rsp_result_slot,
   output logic [gtst_pkg::HANDLE_W-1:0]     rsp_req_handle_out,
   output logic [gtst_pkg::HANDLE_W-1:0]     rsp_work_handle_out,
   input  logic                              csr_we,
   input  logic [gtst_pkg::LOOP_W-1:0]       csr_wdata
);

   localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int LW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0] NO_SLOT = LW'(SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
   localparam logic [gtst_pkg::SLOT_FLD_W:0] SLOTS_W = (gtst_pkg::SLOT_FLD_W + 1)'(SLOTS);

   typedef struct packed {
      logic [gtst_pkg::GEN_W-1:0]    gen;
      gtst_pkg::phase_type           phase;
      logic [gtst_pkg::HANDLE_W-1:0] rh;
      logic [gtst_pkg::HANDLE_W-1:0] wh;
      logic [LW-1:0]                 link;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [LW-1:0] avail_top_ff, avail_top_in;
   logic [gtst_pkg::LOOP_W-1:0] loop_ff;

   // latched request
   gtst_pkg::req_code_type op_ff;
   logic [IW-1:0] addr_ff, addr_in;
   logic hit_ff;
   logic tk_nz_ff;
   logic [gtst_pkg::LOOP_W-1:0] tk_loop_ff;
   logic [gtst_pkg::GEN_W-1:0] gen_ff;
   logic [gtst_pkg::HANDLE_W-1:0] rh_ff, wh_ff;

   // slot memory
   entry_type mem [SLOTS];
   entry_type rd_ff;
   logic mem_re, mem_we;
   logic [IW-1:0] rd_addr, wr_addr;
   entry_type wr_data;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_success_ff, rsp_success_in;
   logic [gtst_pkg::TICKET_W-1:0] rsp_new_ticket_ff, rsp_new_ticket_in;
   logic [gtst_pkg::SLOT_FLD_W-1:0] rsp_result_slot_ff, rsp_result_slot_in;
   logic [gtst_pkg::HANDLE_W-1:0] rsp_rh_ff, rsp_rh_in, rsp_wh_ff, rsp_wh_in;

   logic accept;
   logic [gtst_pkg::SLOT_FLD_W-1:0] tk_slot;
   logic [gtst_pkg::SLOT_FLD_W-1:0] req_addr16;
   logic req_hit;
   logic [gtst_pkg::GEN_W-1:0] req_gen;
   logic [gtst_pkg::GEN_W-1:0] bumped_gen;
   logic live;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign tk_slot = req_ticket[gtst_pkg::SLOT_SHIFT +: gtst_pkg::SLOT_FLD_W];
   assign live = (rd_ff.phase != gtst_pkg::PH_FREE);

   always_comb begin
      bumped_gen = rd_ff.gen + gtst_pkg::GEN_W'(1);
      if (bumped_gen == '0) begin
         bumped_gen = gtst_pkg::GEN_W'(1);
      end
   end

   // address and range check for a new request
   always_comb begin
      req_addr16 = req_slot_index;
      req_hit    = ({1'b0, req_slot_index} < SLOTS_W);
      req_gen    = req_generation;
      case (gtst_pkg::req_code_type'(req_type))
         gtst_pkg::REQ_ARM: begin
            req_addr16 = gtst_pkg::SLOT_FLD_W'(avail_top_ff[IW-1:0]);
            req_hit    = (avail_top_ff != NO_SLOT);
         end
         gtst_pkg::REQ_CLAIM: begin
            req_addr16 = tk_slot;
            req_hit    = ({1'b0, tk_slot} < SLOTS_W);
            req_gen    = req_ticket[gtst_pkg::GEN_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      clr_in             = clr_ff;
      avail_top_in       = avail_top_ff;
      addr_in            = addr_ff;
      mem_re             = 1'b0;
      mem_we             = 1'b0;
      rd_addr            = req_addr16[IW-1:0];
      wr_addr            = addr_ff;
      wr_data            = rd_ff;
      rsp_valid_in       = 1'b0;
      rsp_success_in     = 1'b0;
      rsp_new_ticket_in  = '0;
      rsp_result_slot_in = '0;
      rsp_rh_in          = '0;
      rsp_wh_in          = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            wr_addr       = clr_ff;
            wr_data.gen   = '0;
            wr_data.phase = gtst_pkg::PH_FREE;
            wr_data.rh    = '0;
            wr_data.wh    = '0;
            wr_data.link  = LW'(clr_ff) + LW'(1);
            clr_in        = clr_ff + IW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mem_re   = 1'b1;
               addr_in  = req_addr16[IW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               gtst_pkg::REQ_ARM: begin
                  if (hit_ff) begin
                     mem_we            = 1'b1;
                     wr_data.gen       = bumped_gen;
                     wr_data.phase     = gtst_pkg::PH_ARMED;
                     wr_data.rh        = rh_ff;
                     wr_data.wh        = wh_ff;
                     wr_data.link      = NO_SLOT;
                     avail_top_in      = rd_ff.link;
                     rsp_success_in    = 1'b1;
                     rsp_new_ticket_in = {loop_ff, 8'h00, gtst_pkg::SLOT_FLD_W'(addr_ff),
                                          2'b00, bumped_gen};
                  end
               end
               gtst_pkg::REQ_CLAIM: begin
                  if (hit_ff && tk_nz_ff && tk_loop_ff == loop_ff &&
                      rd_ff.phase == gtst_pkg::PH_ARMED && rd_ff.gen == gen_ff) begin
                     mem_we             = 1'b1;
                     wr_data.phase      = gtst_pkg::PH_RESUMING;
                     rsp_success_in     = 1'b1;
                     rsp_result_slot_in = gtst_pkg::SLOT_FLD_W'(addr_ff);
                  end
               end
               gtst_pkg::REQ_RELEASE: begin
                  if (hit_ff && live) begin
                     mem_we         = 1'b1;
                     wr_data.phase  = gtst_pkg::PH_FREE;
                     wr_data.rh     = '0;
                     wr_data.wh     = '0;
                     wr_data.link   = avail_top_ff;
                     avail_top_in   = LW'(addr_ff);
                     rsp_success_in = 1'b1;
                     rsp_rh_in      = rd_ff.rh;
                     rsp_wh_in      = rd_ff.wh;
                  end
               end
               gtst_pkg::REQ_FORGET: begin
                  if (hit_ff && live && rd_ff.gen == gen_ff) begin
                     mem_we     = 1'b1;
                     wr_data.rh = '0;
                  end
               end
               gtst_pkg::REQ_SCAN: begin
                  if (hit_ff) begin
                     if (rd_ff.phase == gtst_pkg::PH_RESUMING) begin
                        rsp_success_in     = 1'b1;
                        rsp_result_slot_in = gtst_pkg::SLOT_FLD_W'(addr_ff);
                     end else if (addr_ff != LAST_SLOT) begin
                        // keep walking: read the next slot, no result yet
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                        mem_re       = 1'b1;
                        rd_addr      = addr_ff + IW'(1);
                        addr_in      = addr_ff + IW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         avail_top_ff <= '0;
         loop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         avail_top_ff <= avail_top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            loop_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (accept) begin
         op_ff      <= gtst_pkg::req_code_type'(req_type);
         hit_ff     <= req_hit;
         tk_nz_ff   <= (req_ticket != '0);
         tk_loop_ff <= req_ticket[gtst_pkg::LOOP_SHIFT +: gtst_pkg::LOOP_W];
         gen_ff     <= req_gen;
         rh_ff      <= req_handle;
         wh_ff      <= req_work_handle;
      end
      rsp_success_ff     <= rsp_success_in;
      rsp_new_ticket_ff  <= rsp_new_ticket_in;
      rsp_result_slot_ff <= rsp_result_slot_in;
      rsp_rh_ff          <= rsp_rh_in;
      rsp_wh_ff          <= rsp_wh_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_new_ticket      = rsp_new_ticket_ff;
   assign rsp_result_slot     = rsp_result_slot_ff;
   assign rsp_req_handle_out  = rsp_rh_ff;
   assign rsp_work_handle_out = rsp_wh_ff;

   `GTST_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_READ)
   `GTST_ASSERT_NOW(a_rsp_after_read, clock, reset, rsp_valid_ff, $past(state_ff == ST_READ))
   `GTST_ASSERT_NOW(a_ticket_only_ok, clock, reset, rsp_valid_ff && rsp_new_ticket_ff != '0,
                    rsp_success_ff)
   `GTST_ASSERT_NOW(a_write_in_place, clock, reset, mem_we && state_ff == ST_READ,
                    !mem_re)

endmodule

### tb/generational_ticket_slot_table_tb.sv
// Self-checking testbench for the generational ticket slot table.
`timescale 1ns / 1ps

module generational_ticket_slot_table_tb;

   localparam int SLOTS = gtst_pkg::DEF_SLOTS;
   localparam int SETTLE = 4;
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID   = 3'd6;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

   typedef enum {STEP_REQ, STEP_CSR, STEP_DRAIN} step_kind_type;
   // how a request is pointed at live table state when it is presented
   typedef enum {AIM_RAW, AIM_GOOD, AIM_BENT} aim_type;

   typedef struct {
      step_kind_type kind;
      aim_type aim;
      int gap;
      logic [2:0] op;
      logic [gtst_pkg::TICKET_W-1:0] ticket;
      logic [gtst_pkg::SLOT_FLD_W-1:0] slot_index;
      logic [gtst_pkg::GEN_W-1:0] gen;
      logic [gtst_pkg::HANDLE_W-1:0] req_h;
      logic [gtst_pkg::HANDLE_W-1:0] work_h;
      logic [gtst_pkg::LOOP_W-1:0] csr_value;
   } step_type;

   typedef struct {
      logic success;
      logic [gtst_pkg::TICKET_W-1:0] new_ticket;
      logic [gtst_pkg::SLOT_FLD_W-1:0] slot;
      logic [gtst_pkg::HANDLE_W-1:0] req_h;
      logic [gtst_pkg::HANDLE_W-1:0] work_h;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_type = '0;
   logic [gtst_pkg::TICKET_W-1:0] req_ticket = '0;
   logic [gtst_pkg::SLOT_FLD_W-1:0] req_slot_index = '0;
   logic [gtst_pkg::GEN_W-1:0] req_generation = '0;
   logic [gtst_pkg::HANDLE_W-1:0] req_handle = '0;
   logic [gtst_pkg::HANDLE_W-1:0] req_work_handle = '0;
   logic rsp_valid;
   logic rsp_success;
   logic [gtst_pkg::TICKET_W-1:0] rsp_new_ticket;
   logic [gtst_pkg::SLOT_FLD_W-1:0] rsp_result_slot;
   logic [gtst_pkg::HANDLE_W-1:0] rsp_req_handle_out;
   logic [gtst_pkg::HANDLE_W-1:0] rsp_work_handle_out;
   logic csr_we = 1'b0;
   logic [gtst_pkg::LOOP_W-1:0] csr_wdata = '0;

   // shadow of the slot table
   logic [gtst_pkg::LOOP_W-1:0] loop_num;
   logic [8:0] avail_top;
   logic [8:0] link_of[SLOTS];
   logic [gtst_pkg::GEN_W-1:0] gen_of[SLOTS];
   gtst_pkg::phase_type phase_of[SLOTS];
   logic [gtst_pkg::HANDLE_W-1:0] req_of[SLOTS];
   logic [gtst_pkg::HANDLE_W-1:0] work_of[SLOTS];

   step_type pending_q[$];
   outcome_type outcome_q[$];
   step_type cur;
   int quiet;
   int errs = 0;
   int checked = 0;
   int granted = 0;
   int arms_refused = 0;
   int loop_writes = 0;
   int op_seen[8];
   bit gappy = 1'b0;
   int seg_left = 0;

   generational_ticket_slot_table u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_ticket          (req_ticket),
      .req_slot_index      (req_slot_index),
      .req_generation      (req_generation),
      .req_handle          (req_handle),
      .req_work_handle     (req_work_handle),
      .rsp_valid           (rsp_valid),
      .rsp_success         (rsp_success),
      .rsp_new_ticket      (rsp_new_ticket),
      .rsp_result_slot     (rsp_result_slot),
      .rsp_req_handle_out  (rsp_req_handle_out),
      .rsp_work_handle_out (rsp_work_handle_out),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #6 clock = ~clock;

   // Applies one request to the shadow table and returns the result it gives.
   function automatic outcome_type advance_slot_table(step_type s);
      outcome_type o;
      logic [gtst_pkg::GEN_W-1:0] g;
      int sl;
      o = '{success: 1'b0, new_ticket: '0, slot: '0, req_h: '0, work_h: '0};
      case (s.op)
         gtst_pkg::REQ_ARM: begin
            if (avail_top < SLOTS) begin
               sl = int'(avail_top);
               g = gen_of[sl] + gtst_pkg::GEN_W'(1);
               if (g == '0) g = gtst_pkg::GEN_W'(1);
               avail_top = link_of[sl];
               link_of[sl] = 9'(SLOTS);
               req_of[sl] = s.req_h;
               work_of[sl] = s.work_h;
               gen_of[sl] = g;
               phase_of[sl] = gtst_pkg::PH_ARMED;
               o.new_ticket = {loop_num, 8'h00, 16'(sl), 2'b00, g};
               o.success = 1'b1;
            end else begin
               arms_refused++;
            end
         end
         gtst_pkg::REQ_CLAIM: begin
            sl = int'(s.ticket[gtst_pkg::SLOT_SHIFT +: gtst_pkg::SLOT_FLD_W]);
            if (s.ticket != '0 && s.ticket[gtst_pkg::LOOP_SHIFT +: gtst_pkg::LOOP_W] == loop_num
                  && sl < SLOTS && phase_of[sl] == gtst_pkg::PH_ARMED
                  && gen_of[sl] == s.ticket[gtst_pkg::GEN_W-1:0]) begin
               phase_of[sl] = gtst_pkg::PH_RESUMING;
               o.slot = 16'(sl);
               o.success = 1'b1;
            end
         end
         gtst_pkg::REQ_RELEASE: begin
            sl = int'(s.slot_index);
            if (sl < SLOTS && phase_of[sl] != gtst_pkg::PH_FREE) begin
               o.req_h = req_of[sl];
               o.work_h = work_of[sl];
               req_of[sl] = '0;
               work_of[sl] = '0;
               phase_of[sl] = gtst_pkg::PH_FREE;
               link_of[sl] = avail_top;
               avail_top = 9'(sl);
               o.success = 1'b1;
            end
         end
         gtst_pkg::REQ_FORGET: begin
            sl = int'(s.slot_index);
            if (sl < SLOTS && phase_of[sl] != gtst_pkg::PH_FREE && gen_of[sl] == s.gen)
               req_of[sl] = '0;
         end
         gtst_pkg::REQ_SCAN: begin
            for (int i = int'(s.slot_index); i < SLOTS; i++) begin
               if (phase_of[i] == gtst_pkg::PH_RESUMING) begin
                  o.slot = 16'(i);
                  o.success = 1'b1;
                  break;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // Points a request at a real slot (or just off one) using the current table.
   function automatic void aim_step(inout step_type s);
      int armed[$];
      int resuming[$];
      int live[$];
      int idle[$];
      int pick;
      if (s.aim == AIM_RAW) return;
      for (int i = 0; i < SLOTS; i++) begin
         if (phase_of[i] == gtst_pkg::PH_ARMED) armed.push_back(i);
         if (phase_of[i] == gtst_pkg::PH_RESUMING) resuming.push_back(i);
         if (phase_of[i] == gtst_pkg::PH_FREE) idle.push_back(i);
         else live.push_back(i);
      end
      pick = (live.size() != 0) ? live[$urandom_range(0, live.size() - 1)]
                                : $urandom_range(0, SLOTS - 1);
      case (s.op)
         gtst_pkg::REQ_CLAIM: begin
            if (armed.size() != 0) pick = armed[$urandom_range(0, armed.size() - 1)];
            if (s.aim == AIM_BENT && resuming.size() != 0 && $urandom_range(0, 3) == 0)
               pick = resuming[$urandom_range(0, resuming.size() - 1)];
            s.ticket = {loop_num, s.ticket[55:48], 16'(pick), s.ticket[31:30], gen_of[pick]};
            if (s.aim == AIM_BENT) begin
               case ($urandom_range(0, 3))
                  0: s.ticket[63:56] = s.ticket[63:56] ^ 8'($urandom_range(1, 255));
                  1: s.ticket[29:0] = s.ticket[29:0] ^ 30'($urandom_range(1, 1023));
                  2: s.ticket[47:32] = 16'($urandom_range(SLOTS, 65535));
                  default: s.ticket = '0;
               endcase
            end
         end
         gtst_pkg::REQ_RELEASE: begin
            s.slot_index = 16'(pick);
            if (s.aim == AIM_BENT) begin
               if (idle.size() != 0 && $urandom_range(0, 1) == 0)
                  s.slot_index = 16'(idle[$urandom_range(0, idle.size() - 1)]);
               else
                  s.slot_index = 16'($urandom_range(SLOTS, 65535));
            end
         end
         gtst_pkg::REQ_FORGET: begin
            if (s.aim == AIM_BENT && idle.size() != 0 && $urandom_range(0, 2) == 0)
               pick = idle[$urandom_range(0, idle.size() - 1)];
            s.slot_index = 16'(pick);
            s.gen = gen_of[pick];
            if (s.aim == AIM_BENT && $urandom_range(0, 1) == 0)
               s.gen = s.gen ^ 30'($urandom_range(1, 1023));
         end
         gtst_pkg::REQ_SCAN: begin
            if (s.aim == AIM_BENT)
               s.slot_index = 16'($urandom_range(SLOTS, 65535));
            else if (resuming.size() != 0)
               s.slot_index = 16'($urandom_range(0, resuming[$urandom_range(0,
                                 resuming.size() - 1)]));
            else
               s.slot_index = 16'($urandom_range(0, SLOTS - 1));
         end
         default: ;
      endcase
   endfunction

   function automatic step_type fixed_req(logic [2:0] op,
                                          logic [gtst_pkg::TICKET_W-1:0] ticket,
                                          logic [gtst_pkg::SLOT_FLD_W-1:0] idx,
                                          logic [gtst_pkg::GEN_W-1:0] gen,
                                          logic [gtst_pkg::HANDLE_W-1:0] rh,
                                          logic [gtst_pkg::HANDLE_W-1:0] wh);
      step_type s;
      s = '{kind: STEP_REQ, aim: AIM_RAW, gap: 0, op: op, ticket: ticket, slot_index: idx,
            gen: gen, req_h: rh, work_h: wh, csr_value: '0};
      return s;
   endfunction

   function automatic step_type mark(step_kind_type kind, logic [gtst_pkg::LOOP_W-1:0] value);
      step_type s;
      s = fixed_req(gtst_pkg::REQ_ARM, '0, '0, '0, '0, '0);
      s.kind = kind;
      s.csr_value = value;
      return s;
   endfunction

   // Random requests with the given op weights; gaps come in stretches.
   task automatic queue_random_phase(int count, int w_arm, int w_claim, int w_rel,
                                     int w_forget, int w_scan);
      step_type s;
      int r;
      for (int n = 0; n < count; n++) begin
         s = fixed_req(gtst_pkg::REQ_ARM, {$urandom, $urandom}, 16'($urandom),
                       30'($urandom), $urandom, $urandom);
         r = $urandom_range(0, w_arm + w_claim + w_rel + w_forget + w_scan - 1);
         if (r < w_arm) s.op = gtst_pkg::REQ_ARM;
         else if (r < w_arm + w_claim) s.op = gtst_pkg::REQ_CLAIM;
         else if (r < w_arm + w_claim + w_rel) s.op = gtst_pkg::REQ_RELEASE;
         else if (r < w_arm + w_claim + w_rel + w_forget) s.op = gtst_pkg::REQ_FORGET;
         else s.op = gtst_pkg::REQ_SCAN;
         r = $urandom_range(0, 99);
         s.aim = (r < 78) ? AIM_GOOD : (r < 93) ? AIM_BENT : AIM_RAW;
         if ($urandom_range(0, 49) == 0) begin
            s.op = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            s.aim = AIM_RAW;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 80);
            gappy = !gappy;
         end
         seg_left--;
         if (gappy) begin
            r = $urandom_range(0, 9);
            s.gap = (r < 6) ? $urandom_range(1, 3) : (r < 9) ? 0 : $urandom_range(10, 40);
         end
         pending_q.push_back(s);
      end
   endtask

   // Request driver: predicts each transfer as it happens, then presents the next step.
   always @(posedge clock) begin
      logic drive_start;
      logic drive_we;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         loop_num = '0;
         avail_top = '0;
         for (int i = 0; i < SLOTS; i++) begin
            link_of[i] = 9'(i + 1);
            gen_of[i] = '0;
            phase_of[i] = gtst_pkg::PH_FREE;
            req_of[i] = '0;
            work_of[i] = '0;
         end
         quiet = 0;
      end else begin
         drive_start = 1'b0;
         drive_we = 1'b0;
         if (start && !busy) begin
            outcome_q.push_back(advance_slot_table(cur));
            op_seen[cur.op]++;
         end
         if (start && busy) begin
            drive_start = 1'b1;
         end else if (pending_q.size() != 0) begin
            if (pending_q[0].kind != STEP_REQ) begin
               // drain point: hold off until every result is back and the block settles
               if (outcome_q.size() != 0) begin
                  quiet = 0;
               end else if (quiet < SETTLE) begin
                  quiet++;
               end else begin
                  if (pending_q[0].kind == STEP_CSR) begin
                     drive_we = 1'b1;
                     csr_wdata <= pending_q[0].csr_value;
                     loop_num = pending_q[0].csr_value;
                     loop_writes++;
                  end
                  void'(pending_q.pop_front());
                  quiet = 0;
               end
            end else if (pending_q[0].gap > 0) begin
               pending_q[0].gap = pending_q[0].gap - 1;
            end else begin
               cur = pending_q.pop_front();
               aim_step(cur);
               req_type <= cur.op;
               req_ticket <= cur.ticket;
               req_slot_index <= cur.slot_index;
               req_generation <= cur.gen;
               req_handle <= cur.req_h;
               req_work_handle <= cur.work_h;
               drive_start = 1'b1;
            end
         end
         start <= drive_start;
         csr_we <= drive_we;
      end
   end

   // Result monitor: every strobed result is a transfer and must match the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $error("result transfer with no request outstanding");
            errs++;
         end else begin
            want = outcome_q.pop_front();
            checked++;
            if (want.success) granted++;
            if (rsp_success !== want.success) begin
               $error("success: expected %0h, got %0h", want.success, rsp_success);
               errs++;
            end
            if (rsp_new_ticket !== want.new_ticket) begin
               $error("new_ticket: expected %0h, got %0h", want.new_ticket, rsp_new_ticket);
               errs++;
            end
            if (rsp_result_slot !== want.slot) begin
               $error("result_slot: expected %0h, got %0h", want.slot, rsp_result_slot);
               errs++;
            end
            if (rsp_req_handle_out !== want.req_h) begin
               $error("req_handle_out: expected %0h, got %0h", want.req_h, rsp_req_handle_out);
               errs++;
            end
            if (rsp_work_handle_out !== want.work_h) begin
               $error("work_handle_out: expected %0h, got %0h", want.work_h,
                      rsp_work_handle_out);
               errs++;
            end
         end
      end
   end

   initial begin
      // directed: loop number is still zero here
      pending_q.push_back(fixed_req(gtst_pkg::REQ_ARM, '0, '0, '0, 32'hffff_ffff, 32'h0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_ARM, '1, '1, '1, 32'h0, 32'hffff_ffff));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, 64'h0, '0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, '1, '0, '0, '0, '0));   // wrong loop
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, 64'h0000_ffff_0000_0001,
                                    '0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, 64'h0000_0002_0000_0001,
                                    '0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, 64'h0000_0000_0000_0002,
                                    '0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_CLAIM, 64'h00ff_0000_c000_0001,
                                    '0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_FORGET, '0, 16'd1, '1, '0, '0)); // gen off
      pending_q.push_back(fixed_req(gtst_pkg::REQ_FORGET, '0, 16'd1, 30'd1, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_FORGET, '0, '1, 30'd1, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_FORGET, '0, 16'd5, 30'd0, '0, '0)); // free
      pending_q.push_back(fixed_req(gtst_pkg::REQ_SCAN, '0, '1, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_SCAN, '0, 16'd1, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_SCAN, '0, 16'd0, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, '1, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, 16'(SLOTS), '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, 16'd5, '0, '0, '0));
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, 16'd0, '0, '0, '0)); // resuming
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, 16'd1, '0, '0, '0)); // armed
      pending_q.push_back(fixed_req(gtst_pkg::REQ_RELEASE, '0, 16'd1, '0, '0, '0)); // now free
      pending_q.push_back(fixed_req(REQ_UNUSED_FIRST, '1, '1, '1, '1, '1));
      pending_q.push_back(fixed_req(REQ_UNUSED_MID, '1, '1, '1, '1, '1));
      pending_q.push_back(fixed_req(REQ_UNUSED_LAST, '1, '1, '1, '1, '1));
      pending_q.push_back(mark(STEP_DRAIN, '0));
      pending_q.push_back(mark(STEP_CSR, 8'hff));
      queue_random_phase(400, 75, 15, 4, 3, 3);    // arm heavy, runs the table full
      pending_q.push_back(mark(STEP_CSR, 8'h00));
      queue_random_phase(400, 25, 25, 25, 10, 15);
      pending_q.push_back(mark(STEP_DRAIN, '0));
      queue_random_phase(300, 10, 20, 45, 10, 15);
      pending_q.push_back(mark(STEP_CSR, 8'($urandom_range(1, 254))));
      queue_random_phase(400, 30, 25, 20, 10, 15);
      pending_q.push_back(mark(STEP_CSR, 8'h80));
      queue_random_phase(300, 20, 20, 20, 20, 20);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clock);
      // a scan may walk the whole table; give any stray result time to show up
      repeat (2 * SLOTS + 20) @(posedge clock);

      $display(
         "Sent %0d arm, %0d claim, %0d release, %0d forget, %0d scan, %0d unused-code requests",
         op_seen[gtst_pkg::REQ_ARM], op_seen[gtst_pkg::REQ_CLAIM],
         op_seen[gtst_pkg::REQ_RELEASE], op_seen[gtst_pkg::REQ_FORGET],
         op_seen[gtst_pkg::REQ_SCAN],
         op_seen[REQ_UNUSED_FIRST] + op_seen[REQ_UNUSED_MID] + op_seen[REQ_UNUSED_LAST]);
      $display("Checked %0d results (%0d successful), %0d arms hit a full table, %0d loop writes",
               checked, granted, arms_refused, loop_writes);
      if (errs == 0) begin
         $display("generational_ticket_slot_table test passed");
      end else begin
         $display("generational_ticket_slot_table test failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("generational_ticket_slot_table test failed");
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/gtst_pkg.sv
sv/generational_ticket_slot_table.sv
tb/generational_ticket_slot_table_tb.sv
